/* rtl/core/mck_pkg.sv */
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, codes and Morse pattern tables for the character keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int CHAR_W  = 8;
  localparam int TIME_W  = 16;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 3;
  localparam int TDATA_W = 24;
  localparam int MARK_W  = 2;
  localparam int LEN_W   = 3;
  localparam int LETTER_W = 5;

  localparam logic [KIND_W-1:0] KIND_DOT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DASH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GAP  = 2'd2;

  localparam logic [INDEX_W-1:0] REG_DOT       = 3'd0;
  localparam logic [INDEX_W-1:0] REG_DASH      = 3'd1;
  localparam logic [INDEX_W-1:0] REG_MARK_GAP  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_CHAR_GAP  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_WORD_GAP  = 3'd4;

  localparam logic [TIME_W-1:0] DOT_TIME_RST      = 16'd100;
  localparam logic [TIME_W-1:0] DASH_TIME_RST     = 16'd300;
  localparam logic [TIME_W-1:0] MARK_GAP_TIME_RST = 16'd100;
  localparam logic [TIME_W-1:0] CHAR_GAP_TIME_RST = 16'd300;
  localparam logic [TIME_W-1:0] WORD_GAP_TIME_RST = 16'd600;

  localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

  localparam logic [1:0] SEL_MARK = 2'd0;
  localparam logic [1:0] SEL_MGAP = 2'd1;
  localparam logic [1:0] SEL_CGAP = 2'd2;
  localparam logic [1:0] SEL_WGAP = 2'd3;

  typedef struct packed {
    logic       load_char;
    logic       clr_mark;
    logic       inc_mark;
    logic       emit;
    logic [1:0] emit_sel;
    logic       emit_last;
  } mck_cmd_t;

  typedef struct packed {
    logic is_space;
    logic is_letter;
    logic is_final;
    logic last_mark;
    logic out_free;
  } mck_stat_t;

  function automatic logic [LEN_W-1:0] pattern_len(input logic [LETTER_W-1:0] idx);
    logic [LEN_W-1:0] len;
    case (idx)
      5'd0:  len = 3'd2;
      5'd1:  len = 3'd4;
      5'd2:  len = 3'd4;
      5'd3:  len = 3'd3;
      5'd4:  len = 3'd1;
      5'd5:  len = 3'd4;
      5'd6:  len = 3'd3;
      5'd7:  len = 3'd4;
      5'd8:  len = 3'd2;
      5'd9:  len = 3'd4;
      5'd10: len = 3'd3;
      5'd11: len = 3'd4;
      5'd12: len = 3'd2;
      5'd13: len = 3'd2;
      5'd14: len = 3'd3;
      5'd15: len = 3'd4;
      5'd16: len = 3'd4;
      5'd17: len = 3'd3;
      5'd18: len = 3'd3;
      5'd19: len = 3'd1;
      5'd20: len = 3'd3;
      5'd21: len = 3'd4;
      5'd22: len = 3'd3;
      5'd23: len = 3'd4;
      5'd24: len = 3'd4;
      5'd25: len = 3'd4;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] pattern_bits(input logic [LETTER_W-1:0] idx);
    logic [3:0] bits;
    case (idx)
      5'd0:  bits = 4'h2;
      5'd1:  bits = 4'h1;
      5'd2:  bits = 4'h5;
      5'd3:  bits = 4'h1;
      5'd4:  bits = 4'h0;
      5'd5:  bits = 4'h4;
      5'd6:  bits = 4'h3;
      5'd7:  bits = 4'h0;
      5'd8:  bits = 4'h0;
      5'd9:  bits = 4'hE;
      5'd10: bits = 4'h5;
      5'd11: bits = 4'h2;
      5'd12: bits = 4'h3;
      5'd13: bits = 4'h1;
      5'd14: bits = 4'h7;
      5'd15: bits = 4'h6;
      5'd16: bits = 4'hB;
      5'd17: bits = 4'h2;
      5'd18: bits = 4'h0;
      5'd19: bits = 4'h1;
      5'd20: bits = 4'h4;
      5'd21: bits = 4'h8;
      5'd22: bits = 4'h6;
      5'd23: bits = 4'h9;
      5'd24: bits = 4'hD;
      5'd25: bits = 4'h3;
      default: bits = 4'h0;
    endcase
    return bits;
  endfunction

endpackage

/* rtl/core/mck_ctrl.sv */
// ----------------------------------------------------------------------------
// mck_ctrl
// Sequencer that steps through the segments of one character.
// ----------------------------------------------------------------------------
module mck_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mck_pkg::mck_stat_t stat,
  output mck_pkg::mck_cmd_t  cmd
);
  import mck_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MARK   = 3'd2;
  localparam logic [2:0] S_MGAP   = 3'd3;
  localparam logic [2:0] S_WGAP   = 3'd4;
  localparam logic [2:0] S_CGAP   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.emit_sel  = SEL_MARK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_char = 1'b1;
          cmd.clr_mark  = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_space) begin
          state_next = S_WGAP;
        end else if (stat.is_letter) begin
          state_next = S_MARK;
        end else if (!stat.is_final) begin
          state_next = S_CGAP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MARK: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_MARK;
          state_next   = S_MGAP;
        end
      end
      S_MGAP: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_MGAP;
          cmd.emit_last = stat.last_mark && stat.is_final;
          cmd.inc_mark  = 1'b1;
          if (!stat.last_mark) begin
            state_next = S_MARK;
          end else if (stat.is_final) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_CGAP;
          end
        end
      end
      S_WGAP: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_WGAP;
          cmd.emit_last = stat.is_final;
          state_next    = stat.is_final ? S_IDLE : S_CGAP;
        end
      end
      S_CGAP: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_CGAP;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/mck_datapath.sv */
// ----------------------------------------------------------------------------
// mck_datapath
// Timing registers, character decode, mark counter and output register.
// ----------------------------------------------------------------------------
module mck_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mck_pkg::CHAR_W-1:0]      in_char,
  input  logic                            in_final,
  input  logic                            cfg_we,
  input  logic [mck_pkg::INDEX_W-1:0]     cfg_addr,
  input  logic [mck_pkg::TIME_W-1:0]      cfg_wdata,
  input  mck_pkg::mck_cmd_t               cmd,
  output mck_pkg::mck_stat_t              stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mck_pkg::KIND_W-1:0]      out_kind,
  output logic [mck_pkg::TIME_W-1:0]      out_duration,
  output logic                            out_last
);
  import mck_pkg::*;

  logic [TIME_W-1:0]   dot_time;
  logic [TIME_W-1:0]   dash_time;
  logic [TIME_W-1:0]   mark_gap_time;
  logic [TIME_W-1:0]   char_gap_time;
  logic [TIME_W-1:0]   word_gap_time;
  logic [CHAR_W-1:0]   char_reg;
  logic                final_reg;
  logic [MARK_W-1:0]   mark_idx;
  logic [CHAR_W-1:0]   folded;
  logic [CHAR_W-1:0]   letter_full;
  logic [LETTER_W-1:0] letter;
  logic [LEN_W-1:0]    mark_len;
  logic [3:0]          mark_bits;
  logic                mark_dash;
  logic [KIND_W-1:0]   kind_next;
  logic [TIME_W-1:0]   duration_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_time      <= DOT_TIME_RST;
      dash_time     <= DASH_TIME_RST;
      mark_gap_time <= MARK_GAP_TIME_RST;
      char_gap_time <= CHAR_GAP_TIME_RST;
      word_gap_time <= WORD_GAP_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DOT:      dot_time      <= cfg_wdata;
        REG_DASH:     dash_time     <= cfg_wdata;
        REG_MARK_GAP: mark_gap_time <= cfg_wdata;
        REG_CHAR_GAP: char_gap_time <= cfg_wdata;
        REG_WORD_GAP: word_gap_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_char inside {[ASCII_LOWER_A:ASCII_LOWER_Z]}) begin
      folded = in_char - CASE_OFFSET;
    end else begin
      folded = in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_reg  <= folded;
      final_reg <= in_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_mark) begin
      mark_idx <= '0;
    end else if (cmd.inc_mark) begin
      mark_idx <= mark_idx + 1'b1;
    end
  end

  assign letter_full = char_reg - ASCII_UPPER_A;
  assign letter      = letter_full[LETTER_W-1:0];
  assign mark_len    = pattern_len(letter);
  assign mark_bits   = pattern_bits(letter);
  assign mark_dash   = mark_bits[mark_idx];

  assign stat.is_space  = (char_reg == ASCII_SPACE);
  assign stat.is_letter = (char_reg inside {[ASCII_UPPER_A:ASCII_UPPER_Z]});
  assign stat.is_final  = final_reg;
  assign stat.last_mark = ({1'b0, mark_idx} == (mark_len - 3'd1));
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    case (cmd.emit_sel)
      SEL_MARK: begin
        kind_next     = mark_dash ? KIND_DASH : KIND_DOT;
        duration_next = mark_dash ? dash_time : dot_time;
      end
      SEL_MGAP: begin
        kind_next     = KIND_GAP;
        duration_next = mark_gap_time;
      end
      SEL_CGAP: begin
        kind_next     = KIND_GAP;
        duration_next = char_gap_time;
      end
      SEL_WGAP: begin
        kind_next     = KIND_GAP;
        duration_next = word_gap_time;
      end
      default: begin
        kind_next     = KIND_GAP;
        duration_next = mark_gap_time;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind     <= kind_next;
      out_duration <= duration_next;
      out_last     <= cmd.emit_last;
    end
  end

endmodule

/* rtl/core/morse_character_keyer.sv */
// ----------------------------------------------------------------------------
// morse_character_keyer
// Turns ASCII characters into timed Morse keying segments.
//
// Channel   Direction  Payload
// s_*       in         tdata: char_code[7:0]; tlast: final_char
// m_*       out        tdata: segment_kind[1:0], duration[17:2]; tlast: end_of_run
// cfg_*     in         cfg_index selects the register, cfg_data is the value
//
// A character is taken in the idle state and decoded in the cycle after; its
// segments then leave the output register one after another, up to nine for
// a four-mark letter.
// Reset restores the default timings and empties the output register.
// A stall on m_tready holds the sequencer; s_tready is high only when idle.
// ----------------------------------------------------------------------------
module morse_character_keyer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mck_pkg::CHAR_W-1:0]    s_tdata,   // char_code
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mck_pkg::TDATA_W-1:0]   m_tdata,   // segment_kind, duration, zero pad
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mck_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [mck_pkg::TIME_W-1:0]    cfg_data
);
  import mck_pkg::*;

  mck_cmd_t          cmd;
  mck_stat_t         stat;
  logic [KIND_W-1:0] out_kind;
  logic [TIME_W-1:0] out_duration;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(TDATA_W - TIME_W - KIND_W){1'b0}}, out_duration, out_kind};

  mck_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mck_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_char      (s_tdata),
    .in_final     (s_tlast),
    .cfg_we       (cfg_valid),
    .cfg_addr     (cfg_index),
    .cfg_wdata    (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_kind     (out_kind),
    .out_duration (out_duration),
    .out_last     (m_tlast)
  );

endmodule

/* tb/sv/morse_character_keyer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_character_keyer_tb
// Self-checking testbench for the Morse character keyer. Characters go in on
// the slave stream and keying segments come back on the master stream. A
// scoreboard predicts the segments of each accepted character from its own
// Morse table and the current timing registers. Each returned word is then
// compared with the oldest prediction. The run starts with a directed set
// of edge cases and continues with random characters under several timing
// settings and back-pressure patterns.
// ----------------------------------------------------------------------------
module morse_character_keyer_tb;
  import mck_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 80;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] duration;
    logic              run_end;
  } segment_t;

  class segment_scoreboard;
    logic [TIME_W-1:0] timing [5];
    string             morse [26];
    segment_t          segment_q [$];
    int                errors;
    int                chars_seen;
    int                segments_checked;

    function new();
      timing[REG_DOT]      = DOT_TIME_RST;
      timing[REG_DASH]     = DASH_TIME_RST;
      timing[REG_MARK_GAP] = MARK_GAP_TIME_RST;
      timing[REG_CHAR_GAP] = CHAR_GAP_TIME_RST;
      timing[REG_WORD_GAP] = WORD_GAP_TIME_RST;
      morse = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
      errors = 0;
      chars_seen = 0;
      segments_checked = 0;
    endfunction

    function void write_reg(logic [INDEX_W-1:0] index, logic [TIME_W-1:0] value);
      case (index)
        REG_DOT, REG_DASH, REG_MARK_GAP, REG_CHAR_GAP, REG_WORD_GAP: begin
          timing[index] = value;
        end
        default: ;
      endcase
    endfunction

    function void push_segment(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] duration);
      segment_t seg;
      seg.kind = kind;
      seg.duration = duration;
      seg.run_end = 1'b0;
      segment_q.push_back(seg);
    endfunction

    function void note_char(logic [CHAR_W-1:0] code, logic last_char);
      logic [CHAR_W-1:0] c;
      string             pattern;
      int                first;
      c = code;
      first = segment_q.size();
      chars_seen++;
      if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
        c = c - CASE_OFFSET;
      end
      if (c == ASCII_SPACE) begin
        push_segment(KIND_GAP, timing[REG_WORD_GAP]);
      end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
        pattern = morse[c - ASCII_UPPER_A];
        for (int i = 0; i < pattern.len(); i++) begin
          if (pattern[i] == "-") begin
            push_segment(KIND_DASH, timing[REG_DASH]);
          end else begin
            push_segment(KIND_DOT, timing[REG_DOT]);
          end
          push_segment(KIND_GAP, timing[REG_MARK_GAP]);
        end
      end
      if (!last_char) begin
        push_segment(KIND_GAP, timing[REG_CHAR_GAP]);
      end
      if (segment_q.size() > first) begin
        segment_q[segment_q.size() - 1].run_end = 1'b1;
      end
    endfunction

    function void check_segment(logic [TDATA_W-1:0] data, logic run_end);
      segment_t want;
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] duration;
      kind = data[KIND_W-1:0];
      duration = data[KIND_W+TIME_W-1:KIND_W];
      segments_checked++;
      if (segment_q.size() == 0) begin
        $display("%0t: expected no word, actual kind %0d duration %0d end %0b",
                 $time, kind, duration, run_end);
        errors++;
      end else begin
        want = segment_q.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: segment kind expected %0d actual %0d", $time, want.kind, kind);
          errors++;
        end
        if (duration !== want.duration) begin
          $display("%0t: duration expected %0d actual %0d", $time, want.duration, duration);
          errors++;
        end
        if (run_end !== want.run_end) begin
          $display("%0t: end of run expected %0b actual %0b", $time, want.run_end, run_end);
          errors++;
        end
      end
    endfunction

    function int pending();
      return segment_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [CHAR_W-1:0]    s_tdata = '0;   // char_code
  logic                 s_tlast = 1'b0; // final_char
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;        // segment_kind, duration, zero pad
  logic                 m_tlast;        // end_of_run
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [INDEX_W-1:0]   cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;

  segment_scoreboard    board;
  int                   sender_idle_pct = 27;
  int                   receiver_idle_pct = 48;

  // Each entry holds the last-character flag above the character code.
  logic [CHAR_W:0] directed_items [24] = '{
    9'h041, 9'h07A, 9'h161, 9'h15A, 9'h020, 9'h120, 9'h000, 9'h100,
    9'h0FF, 9'h1FF, 9'h040, 9'h05B, 9'h060, 9'h17B, 9'h030, 9'h080,
    9'h051, 9'h048, 9'h04F, 9'h145, 9'h054, 9'h04A, 9'h17F, 9'h079
  };

  morse_character_keyer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_segment(m_tdata, m_tlast);
    end
    m_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog expired with %0d words still awaited.", board.pending());
    $display("simulation failed");
    $finish;
  end

  task automatic send_char(input logic [CHAR_W-1:0] code, input logic last_char);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= code;
    s_tlast <= last_char;
    do @(posedge clk); while (!s_tready);
    board.note_char(code, last_char);
  endtask

  task automatic wait_idle();
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_timing(input logic [TIME_W-1:0] dot_t, dash_t, mark_t,
                                char_t, word_t);
    logic [TIME_W-1:0]  values [5];
    logic [INDEX_W-1:0] regs [5];
    logic [INDEX_W-1:0] stray_index;
    logic [TIME_W-1:0]  stray_data;
    values = '{dot_t, dash_t, mark_t, char_t, word_t};
    regs = '{REG_DOT, REG_DASH, REG_MARK_GAP, REG_CHAR_GAP, REG_WORD_GAP};
    // A write to an unused index must leave every timing unchanged.
    stray_index = INDEX_W'(REG_WORD_GAP + 1 + $urandom_range(2));
    stray_data = TIME_W'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= stray_index;
    cfg_data <= stray_data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(stray_index, stray_data);
    for (int i = 0; i < 5; i++) begin
      cfg_index <= regs[i];
      cfg_data <= values[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(regs[i], values[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      return CHAR_W'(ASCII_UPPER_A + $urandom_range(25));
    end else if (r < 70) begin
      return CHAR_W'(ASCII_LOWER_A + $urandom_range(25));
    end else if (r < 80) begin
      return ASCII_SPACE;
    end
    return CHAR_W'($urandom_range(255));
  endfunction

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_items[i]) begin
      send_char(directed_items[i][CHAR_W-1:0], directed_items[i][CHAR_W]);
    end
    s_tvalid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      if (phase == 2) begin
        sender_idle_pct = 48;
        receiver_idle_pct = 27;
      end else if (phase == 4) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if (phase == 0) begin
        program_timing('0, '0, '0, '0, '0);
      end else if (phase == 1) begin
        program_timing('1, '1, '1, '1, '1);
      end else begin
        program_timing(TIME_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                       TIME_W'($urandom), TIME_W'($urandom));
      end
      repeat (PHASE_ITEMS) begin
        send_char(pick_char(), $urandom_range(99) < 25);
      end
      s_tvalid <= 1'b0;
    end

    wait_idle();
    $display("Sent %0d characters under %0d timing settings; checked %0d segment words.",
             board.chars_seen, PHASES + 1, board.segments_checked);
    $display("Mismatches found: %0d.", board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
